[hw/rtl/word_pattern_replace_stream_unit_assert.svh]
// ----------------------------------------------------------------------------
// word_pattern_replace_stream_unit_assert
// Assertion macros for the word pattern replace stream unit.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORD_PATTERN_REPLACE_STREAM_UNIT_ASSERT_SVH
`define WORD_PATTERN_REPLACE_STREAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WPRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wprs: same-cycle check failed");
`define WPRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wprs: next-cycle check failed");
`else
`define WPRS_ASSERT_IMP(lbl, ante, cons)
`define WPRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/wprs_pkg.sv]
// ----------------------------------------------------------------------------
// wprs_pkg
// Shared types, constants and helpers of the word pattern replace stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wprs_pkg;

	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;
	localparam int LEN_W               = 4;
	localparam int CNT_TOTAL_W         = 24;
	localparam logic [CNT_TOTAL_W-1:0] COUNT_MAX = {CNT_TOTAL_W{1'b1}};
	localparam logic [7:0] SPACE_CHAR  = 8'h20;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_REPL,
		EMIT_HEAD,
		EMIT_SPACE,
		EMIT_MARKER
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_REPL,
		ST_HEAD,
		ST_FLUSH,
		ST_SPACE,
		ST_MARKER
	} state_t;

	typedef struct packed {
		logic  load;   // capture the input word
		logic  push;   // push captured byte into window and compare
		emit_t emit;   // result word to build this cycle
		logic  last;   // result is the last one for this input
		logic  done;   // result is the final one of the text
		logic  clear;  // end of text: clear totals and word state
	} ctl_cmd_t;

	typedef struct packed {
		logic ws;         // captured byte is whitespace
		logic text_end;   // captured byte ends the text
		logic in_word;    // currently inside a word
		logic hit;        // window plus new byte matches the pattern
		logic fits;       // window not yet full after the push
		logic pend_nz;    // window holds bytes
		logic repl_last;  // replacement index at its last byte
		logic out_free;   // output register can take a word
	} dp_status_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == SPACE_CHAR) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic [CNT_TOTAL_W-1:0] sat_add(
		input logic [CNT_TOTAL_W-1:0] a,
		input logic [LEN_W-1:0]       b
	);
		logic [CNT_TOTAL_W:0] s;
		s = {1'b0, a} + {{(CNT_TOTAL_W+1-LEN_W){1'b0}}, b};
		return s[CNT_TOTAL_W] ? COUNT_MAX : s[CNT_TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/wprs_ctrl.sv]
// ----------------------------------------------------------------------------
// wprs_ctrl
// Sequencer: accepts a word, steps the datapath through compare and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module wprs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wprs_pkg::dp_status_t status,
	output wprs_pkg::ctl_cmd_t   cmd
);
	import wprs_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		cmd.emit  = EMIT_NONE;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!status.ws) begin
					cmd.push = 1'b1;
					priority if (status.hit) begin
						state_n = ST_REPL;
					end else if (!status.fits) begin
						state_n = ST_HEAD;
					end else if (status.text_end) begin
						state_n = ST_FLUSH;
					end else begin
						state_n = ST_IDLE;
					end
				end else begin
					priority if (status.in_word) begin
						state_n = ST_FLUSH;
					end else if (status.text_end) begin
						state_n = ST_MARKER;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			ST_REPL: begin
				if (status.out_free) begin
					cmd.emit = EMIT_REPL;
					cmd.last = status.repl_last && !status.text_end;
					if (status.repl_last) begin
						state_n = status.text_end ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_HEAD: begin
				if (status.out_free) begin
					cmd.emit = EMIT_HEAD;
					cmd.last = !status.text_end;
					state_n  = status.text_end ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				// drain leftover window bytes, then the word's space
				if (!status.pend_nz) begin
					state_n = ST_SPACE;
				end else if (status.out_free) begin
					cmd.emit = EMIT_HEAD;
				end
			end
			ST_SPACE: begin
				if (status.out_free) begin
					cmd.emit  = EMIT_SPACE;
					cmd.last  = 1'b1;
					cmd.done  = status.text_end;
					cmd.clear = status.text_end;
					state_n   = ST_IDLE;
				end
			end
			ST_MARKER: begin
				if (status.out_free) begin
					cmd.emit  = EMIT_MARKER;
					cmd.last  = 1'b1;
					cmd.done  = 1'b1;
					cmd.clear = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/wprs_datapath.sv]
// ----------------------------------------------------------------------------
// wprs_datapath
// Config registers, pending window, match compare, totals and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_pattern_replace_stream_unit_assert.svh"

module wprs_datapath #(
	parameter int MAX_PATTERN     = wprs_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = wprs_pkg::MAX_REPLACEMENT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [63:0]                       cfg_data,
	input  logic [7:0]                        in_char,
	input  logic                              text_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_char,
	output logic                              char_valid,
	output logic                              run_end,
	output logic                              text_done,
	output logic [wprs_pkg::CNT_TOTAL_W-1:0]  words_replaced,
	output logic [wprs_pkg::CNT_TOTAL_W-1:0]  chars_changed,
	input  wprs_pkg::ctl_cmd_t                cmd,
	output wprs_pkg::dp_status_t              status
);
	import wprs_pkg::*;

	localparam int WIN    = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
	localparam int RCAP   = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
	localparam int CNT_W  = $clog2(WIN + 1);
	localparam int RIDX_W = (RCAP > 1) ? $clog2(RCAP) : 1;

	function automatic logic [LEN_W-1:0] clamp_len(
		input logic [LEN_W-1:0] v,
		input logic [LEN_W-1:0] cap
	);
		logic [LEN_W-1:0] r;
		r = (v == '0) ? LEN_W'(1) : v;
		return (r > cap) ? cap : r;
	endfunction

	// configuration
	logic [63:0]      pattern_q;
	logic [LEN_W-1:0] plen_q;
	logic [63:0]      repl_q;
	logic [LEN_W-1:0] rlen_q;

	// word state
	logic [7:0]             win_q [WIN];
	logic [CNT_W-1:0]       count_q;
	logic [LEN_W-1:0]       alen_q;
	logic                   inside_q;
	logic [RIDX_W-1:0]      ridx_q;
	logic [CNT_TOTAL_W-1:0] rep_q;
	logic [CNT_TOTAL_W-1:0] chg_q;
	logic [7:0]             char_q;
	logic                   end_q;

	// output register
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   char_valid_q;
	logic                   run_end_q;
	logic                   text_done_q;
	logic [CNT_TOTAL_W-1:0] words_q;
	logic [CNT_TOTAL_W-1:0] chars_q;

	logic [7:0]             win_nxt [WIN];
	logic [LEN_W-1:0]       al_eff;
	logic [LEN_W-1:0]       cnt_nxt;
	logic [LEN_W-1:0]       rl;
	logic                   hit;
	logic                   head_sub;
	logic [7:0]             head_char;
	logic                   out_free;
	logic [7:0]             emit_char;
	logic                   emit_valid;
	logic [CNT_TOTAL_W-1:0] chg_n;

	assign cfg_ready = 1'b1;

	always_comb begin
		al_eff  = (count_q == '0) ? clamp_len(plen_q, LEN_W'(WIN)) : alen_q;
		cnt_nxt = LEN_W'(count_q) + LEN_W'(1);
		rl      = clamp_len(rlen_q, LEN_W'(RCAP));
		for (int i = 0; i < WIN; i++) begin
			win_nxt[i] = (CNT_W'(i) == count_q) ? char_q : win_q[i];
		end
		hit = (cnt_nxt >= al_eff);
		for (int i = 0; i < WIN; i++) begin
			if ((LEN_W'(i) < al_eff) && (win_nxt[i] != pattern_q[8*i +: 8])) begin
				hit = 1'b0;
			end
		end
		head_sub  = (win_q[0] == pattern_q[7:0]);
		head_char = head_sub ? repl_q[7:0] : win_q[0];
		out_free  = !out_valid_q || !out_stall;
	end

	always_comb begin
		emit_char  = 8'h00;
		emit_valid = 1'b1;
		chg_n      = chg_q;
		unique case (cmd.emit)
			EMIT_REPL: begin
				emit_char = repl_q[ridx_q*8 +: 8];
			end
			EMIT_HEAD: begin
				emit_char = head_char;
				if (head_sub) begin
					chg_n = sat_add(chg_q, LEN_W'(1));
				end
			end
			EMIT_SPACE: begin
				emit_char = SPACE_CHAR;
			end
			EMIT_MARKER: begin
				emit_valid = 1'b0;
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		status           = '0;
		status.ws        = is_ws(char_q);
		status.text_end  = end_q;
		status.in_word   = inside_q;
		status.hit       = hit;
		status.fits      = (cnt_nxt < al_eff);
		status.pend_nz   = (count_q != '0);
		status.repl_last = ((LEN_W'(ridx_q) + LEN_W'(1)) == rl);
		status.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= '0;
			plen_q      <= LEN_W'(1);
			repl_q      <= '0;
			rlen_q      <= LEN_W'(1);
			count_q     <= '0;
			alen_q      <= LEN_W'(1);
			inside_q    <= 1'b0;
			ridx_q      <= '0;
			rep_q       <= '0;
			chg_q       <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PATTERN_BYTES:      pattern_q <= cfg_data;
					REG_PATTERN_LENGTH:     plen_q    <= cfg_data[LEN_W-1:0];
					REG_REPLACEMENT_BYTES:  repl_q    <= cfg_data;
					REG_REPLACEMENT_LENGTH: rlen_q    <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				end_q <= text_end;
			end
			if (cmd.push) begin
				inside_q <= 1'b1;
				if (count_q == '0) begin
					alen_q <= al_eff;
				end
				if (hit) begin
					rep_q   <= sat_add(rep_q, LEN_W'(1));
					chg_q   <= sat_add(chg_q, al_eff);
					count_q <= '0;
					ridx_q  <= '0;
				end else begin
					count_q <= cnt_nxt[CNT_W-1:0];
				end
			end
			unique case (cmd.emit)
				EMIT_REPL:  ridx_q   <= ridx_q + RIDX_W'(1);
				EMIT_HEAD: begin
					count_q <= count_q - CNT_W'(1);
					chg_q   <= chg_n;
				end
				EMIT_SPACE: inside_q <= 1'b0;
				default: ;
			endcase
			// word state is already closed here: a space or a bare marker ends the text
			if (cmd.clear) begin
				rep_q    <= '0;
				chg_q    <= '0;
				count_q  <= '0;
			end
			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= in_char;
		end
		if (cmd.push) begin
			for (int i = 0; i < WIN; i++) begin
				win_q[i] <= win_nxt[i];
			end
		end else if (cmd.emit == EMIT_HEAD) begin
			for (int i = 0; i < WIN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
		if (cmd.emit != EMIT_NONE) begin
			out_char_q   <= emit_char;
			char_valid_q <= emit_valid;
			run_end_q    <= cmd.last;
			text_done_q  <= cmd.done;
			words_q      <= rep_q;
			chars_q      <= chg_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_char       = out_char_q;
	assign char_valid     = char_valid_q;
	assign run_end        = run_end_q;
	assign text_done      = text_done_q;
	assign words_replaced = words_q;
	assign chars_changed  = chars_q;

	`WPRS_ASSERT_IMP(a_count_bound, 1'b1, LEN_W'(count_q) <= LEN_W'(WIN))
	`WPRS_ASSERT_IMP(a_emit_free, cmd.emit != EMIT_NONE, out_free)
	`WPRS_ASSERT_IMP(a_done_last, out_valid_q && text_done_q, run_end_q)
	`WPRS_ASSERT_NXT(a_clear_totals, cmd.clear, rep_q == '0 && chg_q == '0 && !inside_q)

endmodule

`default_nettype wire

[hw/rtl/word_pattern_replace_stream_unit.sv]
// ----------------------------------------------------------------------------
// word_pattern_replace_stream_unit
// Per-word streaming find/replace over a byte stream with collapsed spacing.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_stall   in_char, text_end
// out      out  out_valid/out_stall out_char, char_valid, run_end, text_done,
//                                   words_replaced, chars_changed
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word in flight: the sequencer accepts a word, compares it, then moves
// each result word through the output register (up to nine).
// A word end passes an empty-window check between the window drain and the space.
// Downstream stall holds the sequencer in its emit state.
// Reset clears config to pattern/replacement length 1, totals and word counters.
// ----------------------------------------------------------------------------
`default_nettype none

module word_pattern_replace_stream_unit #(
	parameter int MAX_PATTERN     = wprs_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = wprs_pkg::MAX_REPLACEMENT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [63:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_char,
	input  logic                              text_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_char,
	output logic                              char_valid,
	output logic                              run_end,
	output logic                              text_done,
	output logic [wprs_pkg::CNT_TOTAL_W-1:0]  words_replaced,
	output logic [wprs_pkg::CNT_TOTAL_W-1:0]  chars_changed
);
	import wprs_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	wprs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	wprs_datapath #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_char        (in_char),
		.text_end       (text_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_char       (out_char),
		.char_valid     (char_valid),
		.run_end        (run_end),
		.text_done      (text_done),
		.words_replaced (words_replaced),
		.chars_changed  (chars_changed),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

`default_nettype wire
